/* rtl/core/knock_interval_pattern_matcher_core_defines.svh */
// assertion helpers used by the core rtl file
`ifndef KNOCK_INTERVAL_PATTERN_MATCHER_CORE_DEFINES_SVH
`define KNOCK_INTERVAL_PATTERN_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KIPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define KIPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/kipm_pkg.sv */
`default_nettype none

package kipm_pkg;

   // widths of the register fields and the csr port
   localparam int CFG_W       = 16;
   localparam int COUNT_W     = 2;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_W   = 3;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE        = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TOLERANCE       = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_TIMEOUT         = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DISPLAY         = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_INTERVAL_FIRST  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_INTERVAL_SECOND = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_INTERVAL_THIRD  = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_COUNT   = 3'd7;

   // reset values
   localparam logic [CFG_W-1:0]   DEBOUNCE_RESET  = 16'd100;
   localparam logic [CFG_W-1:0]   TOLERANCE_RESET = 16'd100;
   localparam logic [CFG_W-1:0]   TIMEOUT_RESET   = 16'd3000;
   localparam logic [CFG_W-1:0]   DISPLAY_RESET   = 16'd3000;
   localparam logic [COUNT_W-1:0] PATTERN_RESET   = 2'd3;
   localparam int                 MAX_SLOTS       = 3;
   localparam logic [CFG_W-1:0]   INTERVAL_RESET [MAX_SLOTS] = '{16'd250, 16'd600, 16'd250};

   // phase codes
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_LISTEN  = 2'd1;
   localparam logic [1:0] PHASE_SUCCESS = 2'd2;
   localparam logic [1:0] PHASE_FAILURE = 2'd3;

   typedef struct packed {
      logic [CFG_W-1:0]   debounce_ms;
      logic [CFG_W-1:0]   slack_ms;
      logic [CFG_W-1:0]   expiry_ms;
      logic [CFG_W-1:0]   display_ms;
      logic [COUNT_W-1:0] pattern_count;
   } kipm_cfg_type;

   typedef struct packed {
      logic [1:0]         phase;
      logic               granted;
      logic               denied;
      logic [COUNT_W-1:0] matched_count;
   } kipm_result_type;

endpackage

`default_nettype wire

/* rtl/core/kipm_ifs.sv */
`default_nettype none

// knock input channel
interface kipm_req_if;
   logic valid;
   logic ready;
   logic edge_seen;

   modport source (output valid, output edge_seen, input ready);
   modport sink (input valid, input edge_seen, output ready);
endinterface

// result channel
interface kipm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] phase;
   logic       granted;
   logic       denied;
   logic [1:0] matched_count;

   modport source (output valid, output phase, output granted, output denied,
                   output matched_count, input ready);
   modport sink (input valid, input phase, input granted, input denied,
                 input matched_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/kipm_regs.sv */
`default_nettype none

module kipm_regs
   import kipm_pkg::*;
#(
   parameter int PATTERN_SLOTS = 3,
   parameter int SLOT_BITS     = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output kipm_cfg_type               cfg,
   output logic      [CFG_W-1:0]      intervals [PATTERN_SLOTS]
);

   logic [REG_IDX_W-1:0] reg_idx;
   logic [REG_IDX_W-1:0] slot_off;
   logic                 slot_hit;
   logic [SLOT_BITS-1:0] slot;
   logic                 wr_en;

   kipm_cfg_type         cfg_ff;
   logic [CFG_W-1:0]     interval_ff [PATTERN_SLOTS];

   // address decode, interval registers beyond the slot count are absent
   assign reg_idx  = paddr[CSR_ADDR_W-1:2];
   assign slot_off = reg_idx - REG_INTERVAL_FIRST;
   assign slot_hit = (reg_idx >= REG_INTERVAL_FIRST) && (reg_idx != REG_PATTERN_COUNT) &&
                     (slot_off < REG_IDX_W'(PATTERN_SLOTS));
   assign slot     = slot_off[SLOT_BITS-1:0];
   assign wr_en    = psel && penable && pwrite;

   // scalar registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.slack_ms      <= TOLERANCE_RESET;
         cfg_ff.expiry_ms     <= TIMEOUT_RESET;
         cfg_ff.display_ms    <= DISPLAY_RESET;
         cfg_ff.pattern_count <= PATTERN_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_DEBOUNCE:      cfg_ff.debounce_ms   <= pwdata[CFG_W-1:0];
            REG_TOLERANCE:     cfg_ff.slack_ms      <= pwdata[CFG_W-1:0];
            REG_TIMEOUT:       cfg_ff.expiry_ms     <= pwdata[CFG_W-1:0];
            REG_DISPLAY:       cfg_ff.display_ms    <= pwdata[CFG_W-1:0];
            REG_PATTERN_COUNT: cfg_ff.pattern_count <= pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // pattern interval registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_SLOTS; i++) begin
            interval_ff[i] <= INTERVAL_RESET[i];
         end
      end else if (wr_en && slot_hit) begin
         interval_ff[slot] <= pwdata[CFG_W-1:0];
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_DEBOUNCE:      prdata = CSR_DATA_W'(cfg_ff.debounce_ms);
         REG_TOLERANCE:     prdata = CSR_DATA_W'(cfg_ff.slack_ms);
         REG_TIMEOUT:       prdata = CSR_DATA_W'(cfg_ff.expiry_ms);
         REG_DISPLAY:       prdata = CSR_DATA_W'(cfg_ff.display_ms);
         REG_PATTERN_COUNT: prdata = CSR_DATA_W'(cfg_ff.pattern_count);
         default: begin
            if (slot_hit) begin
               prdata = CSR_DATA_W'(interval_ff[slot]);
            end
         end
      endcase
   end

   assign cfg       = cfg_ff;
   assign intervals = interval_ff;

endmodule

`default_nettype wire

/* rtl/core/kipm_tracker.sv */
`default_nettype none

module kipm_tracker
   import kipm_pkg::*;
#(
   parameter int PATTERN_SLOTS = 3,
   parameter int SLOT_BITS     = 2,
   parameter int TIME_BITS     = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire kipm_cfg_type cfg,
   input  wire logic [CFG_W-1:0] intervals [PATTERN_SLOTS],
   input  wire logic         step,
   input  wire logic         edge_seen,
   output kipm_result_type   result
);

   localparam int GAP_W = TIME_BITS + 1;

   // register value truncated to the time width, one guard bit on top
   function automatic logic [GAP_W-1:0] to_gap(input logic [CFG_W-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      return {1'b0, wide[TIME_BITS-1:0]};
   endfunction

   function automatic logic [GAP_W-1:0] sat_inc(input logic [GAP_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   logic [1:0]         phase_ff,     phase_in;
   logic [GAP_W-1:0]   edge_gap_ff,  edge_gap_in;
   logic [GAP_W-1:0]   knock_gap_ff, knock_gap_in;
   logic [GAP_W-1:0]   disp_ff,      disp_in;
   logic [COUNT_W-1:0] match_ff,     match_in;

   logic [GAP_W-1:0]   edge_el;
   logic [GAP_W-1:0]   knock_el;
   logic [GAP_W-1:0]   disp_el;
   logic [GAP_W-1:0]   expected;
   logic [GAP_W-1:0]   deviation;
   logic [COUNT_W-1:0] match_next;
   logic [SLOT_BITS-1:0] slot;
   logic               knock;
   logic               granted;
   logic               denied;

   // advanced counters for this tick
   assign edge_el  = sat_inc(edge_gap_ff);
   assign knock_el = sat_inc(knock_gap_ff);
   assign disp_el  = sat_inc(disp_ff);
   assign knock    = edge_seen && (edge_el > to_gap(cfg.debounce_ms));

   // pattern entry for the next interval, clamped to the last slot
   assign slot = (match_ff >= COUNT_W'(PATTERN_SLOTS)) ? SLOT_BITS'(PATTERN_SLOTS - 1) :
                 match_ff[SLOT_BITS-1:0];
   assign expected   = to_gap(intervals[slot]);
   assign deviation  = (knock_el > expected) ? knock_el - expected : expected - knock_el;
   assign match_next = match_ff + 1'b1;

   // next state for one tick
   always_comb begin
      phase_in     = phase_ff;
      knock_gap_in = knock_gap_ff;
      disp_in      = disp_ff;
      match_in     = match_ff;
      granted      = 1'b0;
      denied       = 1'b0;
      edge_gap_in  = edge_seen ? '0 : edge_el;

      unique case (phase_ff)
         PHASE_IDLE: begin
            if (knock) begin
               phase_in     = PHASE_LISTEN;
               knock_gap_in = '0;
               match_in     = '0;
            end
         end
         PHASE_LISTEN: begin
            if (knock_el > to_gap(cfg.expiry_ms)) begin
               phase_in = PHASE_FAILURE;
               disp_in  = '0;
               denied   = 1'b1;
            end else if (knock) begin
               if (deviation <= to_gap(cfg.slack_ms)) begin
                  match_in     = match_next;
                  knock_gap_in = '0;
                  if (match_next >= cfg.pattern_count) begin
                     phase_in = PHASE_SUCCESS;
                     disp_in  = '0;
                     granted  = 1'b1;
                  end
               end else begin
                  phase_in = PHASE_FAILURE;
                  disp_in  = '0;
                  denied   = 1'b1;
               end
            end else begin
               knock_gap_in = knock_el;
            end
         end
         default: begin
            // success or failure shown
            if (disp_el > to_gap(cfg.display_ms)) begin
               phase_in     = PHASE_IDLE;
               disp_in      = '0;
               match_in     = '0;
               knock_gap_in = '0;
            end else begin
               disp_in = disp_el;
            end
         end
      endcase
   end

   // state registers, advance once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         edge_gap_ff  <= '1;
         knock_gap_ff <= '0;
         disp_ff      <= '0;
         match_ff     <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         edge_gap_ff  <= edge_gap_in;
         knock_gap_ff <= knock_gap_in;
         disp_ff      <= disp_in;
         match_ff     <= match_in;
      end
   end

   assign result.phase         = phase_in;
   assign result.granted       = granted;
   assign result.denied        = denied;
   assign result.matched_count = match_in;

endmodule

`default_nettype wire

/* rtl/core/knock_interval_pattern_matcher_core.sv */
// channel   direction  payload
// req_link  in         edge_seen (one beat per millisecond tick)
// rsp_link  out        phase, granted, denied, matched_count (one beat per tick)
// csr       apb r/w    registers at byte address 4*index, pready tied high
//
// one beat per cycle sustained while the result side is ready; a beat's result passes
// through the input register, the tracker update and the result register
// reset is synchronous; state returns to idle and registers to their defaults
// a stalled result holds in the result register while the input register takes
// one more beat; req ready drops only when both are full
`default_nettype none

`include "knock_interval_pattern_matcher_core_defines.svh"

module knock_interval_pattern_matcher_core
   import kipm_pkg::*;
#(
   parameter int PATTERN_SLOTS = 3,
   parameter int TIME_BITS     = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   kipm_req_if.sink                   req_link,
   kipm_rsp_if.source                 rsp_link,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int SLOT_BITS = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;

   kipm_cfg_type    cfg;
   logic [CFG_W-1:0] intervals [PATTERN_SLOTS];
   kipm_result_type result;

   logic            in_valid_ff, in_valid_in;
   logic            in_edge_ff;
   logic            out_valid_ff, out_valid_in;
   kipm_result_type out_ff;
   logic            step;
   logic            req_take;

   assign pready = 1'b1;

   // configuration registers
   kipm_regs #(
      .PATTERN_SLOTS (PATTERN_SLOTS),
      .SLOT_BITS     (SLOT_BITS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .cfg       (cfg),
      .intervals (intervals)
   );

   // handshake: the tracker steps when the result register can take the result
   assign step            = in_valid_ff && (!out_valid_ff || rsp_link.ready);
   assign req_link.ready  = !in_valid_ff || step;
   assign req_take        = req_link.valid && req_link.ready;
   assign in_valid_in     = req_take || (in_valid_ff && !step);
   assign out_valid_in    = step || (out_valid_ff && !rsp_link.ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_edge_ff <= req_link.edge_seen;
      end
   end

   // knock tracking state machine
   kipm_tracker #(
      .PATTERN_SLOTS (PATTERN_SLOTS),
      .SLOT_BITS     (SLOT_BITS),
      .TIME_BITS     (TIME_BITS)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .intervals (intervals),
      .step      (step),
      .edge_seen (in_edge_ff),
      .result    (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_link.valid         = out_valid_ff;
   assign rsp_link.phase         = out_ff.phase;
   assign rsp_link.granted       = out_ff.granted;
   assign rsp_link.denied        = out_ff.denied;
   assign rsp_link.matched_count = out_ff.matched_count;

   // checks
   `KIPM_ASSERT_NOW(a_granted_success, clock, reset, out_valid_ff && out_ff.granted,
      out_ff.phase == PHASE_SUCCESS, "granted beat outside success phase")
   `KIPM_ASSERT_NOW(a_denied_failure, clock, reset, out_valid_ff && out_ff.denied,
      out_ff.phase == PHASE_FAILURE, "denied beat outside failure phase")
   `KIPM_ASSERT_NEXT(a_idle_no_match, clock, reset, step && (result.phase == PHASE_IDLE),
      out_ff.matched_count == '0, "match count not cleared in idle")

endmodule

`default_nettype wire

/* tb/tb_knock_interval_pattern_matcher_core.sv */
`timescale 1ns / 1ps

module tb_knock_interval_pattern_matcher_core;
   import kipm_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_TICKS  = 1550;
   localparam int PRINT_LIMIT   = 100;
   localparam int TIME_CAP      = 40;

   // session flavors
   localparam int SESSION_RANDOM = 0;
   localparam int SESSION_ZERO   = 1;
   localparam int SESSION_MAX    = 2;
   localparam int SESSION_WIDE   = 3;

   // expected tick outcomes from a software copy of the knock tracker
   class knock_outcome_board;
      logic [CFG_W-1:0]   debounce_ms;
      logic [CFG_W-1:0]   slack_ms;
      logic [CFG_W-1:0]   expiry_ms;
      logic [CFG_W-1:0]   display_ms;
      logic [CFG_W-1:0]   interval_ms [MAX_SLOTS];
      logic [COUNT_W-1:0] pattern_count;

      logic [1:0]         phase_now;
      logic [CFG_W:0]     edge_gap;
      logic [CFG_W:0]     knock_gap;
      logic [CFG_W:0]     display_elapsed;
      logic [COUNT_W-1:0] match_index;

      kipm_result_type    pending_outcomes [$];
      int                 error_count;
      int                 checked_count;

      function new();
         debounce_ms     = DEBOUNCE_RESET;
         slack_ms        = TOLERANCE_RESET;
         expiry_ms       = TIMEOUT_RESET;
         display_ms      = DISPLAY_RESET;
         interval_ms[0]  = INTERVAL_RESET[0];
         interval_ms[1]  = INTERVAL_RESET[1];
         interval_ms[2]  = INTERVAL_RESET[2];
         pattern_count   = PATTERN_RESET;
         phase_now       = PHASE_IDLE;
         edge_gap        = '1;
         knock_gap       = '0;
         display_elapsed = '0;
         match_index     = '0;
         error_count     = 0;
         checked_count   = 0;
      endfunction

      function void set_register(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
         case (idx)
            REG_DEBOUNCE:        debounce_ms    = value;
            REG_TOLERANCE:       slack_ms       = value;
            REG_TIMEOUT:         expiry_ms      = value;
            REG_DISPLAY:         display_ms     = value;
            REG_INTERVAL_FIRST:  interval_ms[0] = value;
            REG_INTERVAL_SECOND: interval_ms[1] = value;
            REG_INTERVAL_THIRD:  interval_ms[2] = value;
            REG_PATTERN_COUNT:   pattern_count  = value[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // saturating millisecond counter step
      function logic [CFG_W:0] bump(logic [CFG_W:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      function logic [CFG_W-1:0] entry_for(logic [COUNT_W-1:0] idx);
         if (idx == 2'd0) return interval_ms[0];
         if (idx == 2'd1) return interval_ms[1];
         return interval_ms[2];
      endfunction

      // advance one tick and queue the outcome it must produce
      function void note_tick(logic edge_seen);
         logic [CFG_W:0]  eg;
         logic [CFG_W:0]  el;
         logic [CFG_W:0]  de;
         logic [CFG_W:0]  ex;
         logic [CFG_W:0]  diff;
         logic            knock;
         kipm_result_type outcome;
         knock = 1'b0;
         outcome.granted = 1'b0;
         outcome.denied  = 1'b0;

         // debounce on the raw edge gap, every edge restarts it
         eg = bump(edge_gap);
         if (edge_seen) begin
            knock = (eg > {1'b0, debounce_ms});
            edge_gap = '0;
         end else begin
            edge_gap = eg;
         end

         case (phase_now)
            PHASE_IDLE: begin
               if (knock) begin
                  phase_now   = PHASE_LISTEN;
                  knock_gap   = '0;
                  match_index = '0;
               end
            end
            PHASE_LISTEN: begin
               el = bump(knock_gap);
               // timeout wins over a knock on the same tick
               if (el > {1'b0, expiry_ms}) begin
                  phase_now       = PHASE_FAILURE;
                  display_elapsed = '0;
                  outcome.denied  = 1'b1;
               end else if (knock) begin
                  ex   = {1'b0, entry_for(match_index)};
                  diff = (el > ex) ? el - ex : ex - el;
                  if (diff <= {1'b0, slack_ms}) begin
                     match_index = match_index + 2'd1;
                     knock_gap   = '0;
                     if (match_index >= pattern_count) begin
                        phase_now       = PHASE_SUCCESS;
                        display_elapsed = '0;
                        outcome.granted = 1'b1;
                     end
                  end else begin
                     phase_now       = PHASE_FAILURE;
                     display_elapsed = '0;
                     outcome.denied  = 1'b1;
                  end
               end else begin
                  knock_gap = el;
               end
            end
            default: begin
               // success or failure held, knocks ignored
               de = bump(display_elapsed);
               if (de > {1'b0, display_ms}) begin
                  phase_now       = PHASE_IDLE;
                  display_elapsed = '0;
                  match_index     = '0;
                  knock_gap       = '0;
               end else begin
                  display_elapsed = de;
               end
            end
         endcase

         outcome.phase         = phase_now;
         outcome.matched_count = match_index;
         pending_outcomes.push_back(outcome);
      endfunction

      task report_mismatch(string what);
         if (error_count < PRINT_LIMIT)
            $display("mismatch at result beat %0d: %s", checked_count, what);
         error_count++;
      endtask

      // compare one result beat with the oldest expected outcome
      task check_outcome(kipm_result_type got);
         kipm_result_type want;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result beat with no tick outstanding");
            checked_count++;
            return;
         end
         want = pending_outcomes.pop_front();
         if (got.phase !== want.phase)
            report_mismatch($sformatf("phase got %0d want %0d", got.phase, want.phase));
         if (got.granted !== want.granted)
            report_mismatch($sformatf("granted got %0b want %0b", got.granted, want.granted));
         if (got.denied !== want.denied)
            report_mismatch($sformatf("denied got %0b want %0b", got.denied, want.denied));
         if (got.matched_count !== want.matched_count)
            report_mismatch($sformatf("matched_count got %0d want %0d",
                                      got.matched_count, want.matched_count));
         checked_count++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   kipm_req_if req_bus ();
   kipm_rsp_if rsp_bus ();

   knock_outcome_board board = new();

   int tick_total  = 0;
   int cycle_count = 0;
   bit steady_flow = 1'b0;

   // settings of the running session
   logic [CFG_W-1:0]   plan_debounce;
   logic [CFG_W-1:0]   plan_slack;
   logic [CFG_W-1:0]   plan_expiry;
   logic [CFG_W-1:0]   plan_display;
   logic [CFG_W-1:0]   plan_interval [MAX_SLOTS];
   logic [COUNT_W-1:0] plan_count;

   knock_interval_pattern_matcher_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_link (req_bus),
      .rsp_link (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #1 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function int draw_wait();
      if (steady_flow) return 0;
      return $urandom_range(0, 18);
   endfunction

   function int clip(int v, int lim);
      return (v > lim) ? lim : v;
   endfunction

   // mostly in range, sometimes an extreme
   function logic [CFG_W-1:0] pick_time(int lo, int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return CFG_W'($urandom_range(lo, hi));
   endfunction

   // result side: random stalls, check every accepted beat
   initial begin
      kipm_result_type got;
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.phase         = rsp_bus.phase;
         got.granted       = rsp_bus.granted;
         got.denied        = rsp_bus.denied;
         got.matched_count = rsp_bus.matched_count;
         board.check_outcome(got);
      end
   end

   // one tick beat, valid held high across back-to-back beats
   task send_tick(logic edge_bit);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.edge_seen <= edge_bit;
      do @(posedge clock); while (!req_bus.ready);
      board.note_tick(edge_bit);
      tick_total++;
   endtask

   task send_quiet(int n);
      repeat (n) send_tick(1'b0);
   endtask

   // msb first
   task send_pattern(logic [31:0] bits, int n);
      for (int i = n - 1; i >= 0; i--) send_tick(bits[i]);
   endtask

   // stop sending and wait for every outstanding result
   task settle_block();
      req_bus.valid <= 1'b0;
      while (board.pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb setup then access; psel stays up across consecutive writes
   task write_csr(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {{(CSR_DATA_W-CFG_W){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_register(idx, value);
   endtask

   task program_registers(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] tol,
                          logic [CFG_W-1:0] tmo, logic [CFG_W-1:0] disp,
                          logic [CFG_W-1:0] iv0, logic [CFG_W-1:0] iv1,
                          logic [CFG_W-1:0] iv2, logic [COUNT_W-1:0] cnt);
      plan_debounce    = deb;
      plan_slack       = tol;
      plan_expiry      = tmo;
      plan_display     = disp;
      plan_interval[0] = iv0;
      plan_interval[1] = iv1;
      plan_interval[2] = iv2;
      plan_count       = cnt;
      write_csr(REG_DEBOUNCE, deb);
      write_csr(REG_TOLERANCE, tol);
      write_csr(REG_TIMEOUT, tmo);
      write_csr(REG_DISPLAY, disp);
      write_csr(REG_INTERVAL_FIRST, iv0);
      write_csr(REG_INTERVAL_SECOND, iv1);
      write_csr(REG_INTERVAL_THIRD, iv2);
      write_csr(REG_PATTERN_COUNT, {{(CFG_W-COUNT_W){1'b0}}, cnt});
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // a knock sequence aimed at the programmed pattern, with jitter and misses
   task knock_attempt();
      int entries;
      int ticks;
      int ex;
      int lim_tol;
      int offset;
      int pick;
      bit bounce;
      if ($urandom_range(0, 9) == 0) settle_block();
      send_quiet(clip(plan_debounce, TIME_CAP) + 1 + $urandom_range(0, 3));
      send_tick(1'b1);
      entries = ((plan_count == 0) ? 1 : plan_count) + (($urandom_range(0, 5) == 0) ? 1 : 0);
      for (int k = 0; k < entries; k++) begin
         ex      = clip(plan_interval[(k > 2) ? 2 : k], 60);
         lim_tol = clip(plan_slack, 8);
         pick    = $urandom_range(0, 9);
         if (pick < 7) begin
            offset = $urandom_range(0, lim_tol);
            ticks  = $urandom_range(0, 1) ? ex + offset : ex - offset;
         end else if (pick == 7) begin
            offset = lim_tol + $urandom_range(1, 3);
            ticks  = $urandom_range(0, 1) ? ex + offset : ex - offset;
         end else if (pick == 8) begin
            ticks = clip(plan_expiry, 70) + $urandom_range(0, 2);
         end else begin
            ticks = $urandom_range(1, 70);
         end
         if (ticks < 1) ticks = 1;
         bounce = ($urandom_range(0, 4) == 0);
         for (int j = 1; j < ticks; j++) send_tick(bounce && j == 1);
         send_tick(1'b1);
      end
      // ride out the display hold, with stray knocks
      repeat (clip(plan_display, TIME_CAP) + 2) send_tick($urandom_range(0, 7) == 0);
   endtask

   task noise_burst();
      repeat ($urandom_range(5, 30)) send_tick($urandom_range(0, 2) == 0);
   endtask

   task run_session(int flavor);
      logic [CFG_W-1:0] deb;
      logic [CFG_W-1:0] lim;
      deb = pick_time(0, 6);
      lim = clip(deb, TIME_CAP);
      settle_block();
      case (flavor)
         SESSION_ZERO: program_registers('0, '0, '0, '0, '0, '0, '0, 2'd0);
         SESSION_MAX:  program_registers('1, '1, '1, '1, '1, '1, '1, 2'd3);
         SESSION_WIDE: program_registers('0, '1, '1, '0, '1, 16'd5, '1, 2'd3);
         default: begin
            program_registers(deb, pick_time(0, 4), pick_time(35, 70), pick_time(0, 25),
                              pick_time(lim + 1, lim + 25), pick_time(lim + 1, lim + 25),
                              pick_time(lim + 1, lim + 25), COUNT_W'($urandom_range(0, 3)));
         end
      endcase
      steady_flow = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 4) == 0) noise_burst();
         else knock_attempt();
      end
   endtask

   initial begin
      int goal;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.edge_seen <= 1'b0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first knock straight out of reset with the default settings
      send_tick(1'b1);
      settle_block();

      // count zero success, display knocks, knock on the timeout tick
      program_registers(16'd0, 16'd0, 16'd3, 16'd1, 16'd2, 16'd1, 16'd3, 2'd0);
      send_pattern(32'b101111000100, 12);
      settle_block();

      // bounce rejection and a wrong interval
      program_registers(16'd1, 16'd0, 16'd3, 16'd1, 16'd2, 16'd1, 16'd3, 2'd3);
      send_pattern(32'b110100, 6);
      settle_block();

      // full three entry match, immediate return to idle
      program_registers(16'd1, 16'd1, 16'd5, 16'd0, 16'd2, 16'd3, 16'd1, 2'd3);
      send_pattern(32'b101001010, 9);

      // register extremes
      run_session(SESSION_ZERO);
      run_session(SESSION_WIDE);
      run_session(SESSION_MAX);

      // random sessions
      goal = tick_total + RANDOM_TICKS;
      while (tick_total < goal) run_session(SESSION_RANDOM);

      settle_block();
      repeat (8) @(posedge clock);
      if (board.error_count == 0 && board.pending_outcomes.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
